>>> hdl/adaptive_rrip_lfu_replacement_assert.svh
// Assertion macros used by the checker file
`ifndef ADAPTIVE_RRIP_LFU_REPLACEMENT_ASSERT_SVH
`define ADAPTIVE_RRIP_LFU_REPLACEMENT_ASSERT_SVH

// implication checked on every edge outside reset
`define ARL_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// implication checked in the next cycle
`define ARL_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

>>> hdl/arl_pkg.sv
package arl_pkg;

    localparam int NUM_SETS  = 2048;
    localparam int NUM_WAYS  = 16;
    localparam int SET_W     = 11;
    localparam int WAY_W     = 4;
    localparam int LINE_W    = SET_W + WAY_W;

    localparam logic [1:0] MODE_SRRIP   = 2'd0;
    localparam logic [1:0] MODE_LFU     = 2'd1;
    localparam logic [1:0] MODE_SPATIAL = 2'd2;

    localparam logic [1:0] RRV_MAX          = 2'd3;
    localparam logic [1:0] RRV_SRRIP_INSERT = 2'd2;
    localparam logic [7:0] FREQ_MAX         = 8'd255;
    localparam logic [2:0] WARMUP_DONE      = 3'd5;

    localparam logic [15:0] PERIOD_RESET = 16'd1024;
    localparam logic [11:0] TOL_RESET    = 12'd64;

    localparam logic ACT_QUERY  = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    localparam logic [0:0] ADDR_PERIOD = 1'b0;
    localparam logic [0:0] ADDR_TOL    = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clr_step;     // clearing pass write
        logic load;         // capture input word
        logic read_set;     // issue set reads
        logic scan;         // victim scan step
        logic stride;       // stride against the overwritten slot
        logic eval;         // history/mode evaluation
        logic commit;       // write back
        logic out;          // present result
    } arl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic is_query;
        logic set_ok;
    } arl_stat_t;

endpackage

>>> hdl/arl_ctrl.sv
module arl_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output arl_pkg::arl_cmd_t  cmd,
    input  arl_pkg::arl_stat_t stat
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_SCAN, S_STRIDE, S_EVAL, S_COMMIT, S_OUT
    } state_t;

    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:  if (stat.clr_done) state_reg <= S_IDLE;
                S_IDLE:   if (start) state_reg <= S_READ;
                S_READ:
                begin
                    if (!stat.set_ok)        state_reg <= S_OUT;
                    else if (stat.is_query)  state_reg <= S_SCAN;
                    else                     state_reg <= S_STRIDE;
                end
                S_SCAN:   if (stat.scan_done) state_reg <= S_OUT;
                S_STRIDE: state_reg <= S_EVAL;
                S_EVAL:   state_reg <= S_COMMIT;
                S_COMMIT: state_reg <= S_OUT;
                S_OUT:    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign cmd.clr_step = (state_reg == S_CLEAR);
    assign cmd.load     = (state_reg == S_IDLE) && start;
    assign cmd.read_set = (state_reg == S_READ);
    assign cmd.scan     = (state_reg == S_SCAN);
    assign cmd.stride   = (state_reg == S_STRIDE);
    assign cmd.eval     = (state_reg == S_EVAL);
    assign cmd.commit   = (state_reg == S_COMMIT);
    assign cmd.out      = (state_reg == S_OUT);

endmodule

>>> hdl/arl_dp.sv
module arl_dp
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  arl_pkg::arl_cmd_t         cmd,
    output arl_pkg::arl_stat_t        stat,
    input  logic [15:0]               reeval_period,
    input  logic [11:0]               stride_tolerance,
    input  logic                      action,
    input  logic [arl_pkg::SET_W-1:0] set_index,
    input  logic [arl_pkg::WAY_W-1:0] way_index,
    input  logic [63:0]               phys_addr,
    input  logic [63:0]               prog_counter,
    input  logic                      was_hit,
    output logic                      done,
    output logic [arl_pkg::WAY_W-1:0] victim_way,
    output logic [1:0]                set_mode
);

    // line memories: rrv and frequency, one line per cycle
    logic [1:0] rrv_mem  [arl_pkg::NUM_SETS*arl_pkg::NUM_WAYS];
    logic [7:0] freq_mem [arl_pkg::NUM_SETS*arl_pkg::NUM_WAYS];
    // per-set history memories, all slots of a set in one row
    logic [3:0][63:0] pc_mem   [arl_pkg::NUM_SETS];
    logic [3:0][63:0] addr_mem [arl_pkg::NUM_SETS];
    logic [2:0][63:0] str_mem  [arl_pkg::NUM_SETS];
    // packed per-set word: pc_slot, addr_slot, mode, period, warmup
    logic [24:0] meta_mem [arl_pkg::NUM_SETS];

    // captured word
    logic                      act_reg;
    logic [arl_pkg::SET_W-1:0] set_reg;
    logic [arl_pkg::WAY_W-1:0] way_reg;
    logic [63:0]               addr_reg;
    logic [63:0]               pc_reg;
    logic                      hit_reg;
    logic                      set_ok_reg;

    logic [arl_pkg::LINE_W:0]  clr_cnt_reg;
    logic [arl_pkg::WAY_W:0]   scan_cnt_reg;
    logic                      scan_rd_reg;

    // read data
    logic [1:0]       rrv_rd_reg;
    logic [7:0]       freq_rd_reg;
    logic [24:0]      meta_rd_reg;
    logic [3:0][63:0] pc_rd_reg;
    logic [3:0][63:0] addr_rd_reg;
    logic [2:0][63:0] str_rd_reg;

    // scan best
    logic [1:0]              top_reg;
    logic [8:0]              least_reg;
    logic [arl_pkg::WAY_W-1:0] best_reg;

    // evaluation results
    logic [24:0] meta_new_reg;
    logic [63:0] stride_new_reg;

    logic [arl_pkg::LINE_W-1:0] line_addr;
    assign line_addr = cmd.scan ? {set_reg, scan_cnt_reg[arl_pkg::WAY_W-1:0]}
                                : {set_reg, way_reg};

    assign stat.clr_done  = clr_cnt_reg[arl_pkg::LINE_W];
    assign stat.scan_done = scan_rd_reg && scan_cnt_reg[arl_pkg::WAY_W];
    assign stat.is_query  = (act_reg == arl_pkg::ACT_QUERY);
    assign stat.set_ok    = set_ok_reg;

    // meta fields of the read word
    logic [1:0]  ps, as, md;
    logic [15:0] pcnt;
    logic [2:0]  wcnt;
    assign {ps, as, md, pcnt, wcnt} = meta_rd_reg;

    // history rows after this access
    logic [3:0][63:0] pcs;
    logic [3:0][63:0] addrs;
    logic [2:0][63:0] strs;
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pcs[i]   = (ps == 2'(i)) ? pc_reg : pc_rd_reg[i];
            addrs[i] = (as == 2'(i)) ? addr_reg : addr_rd_reg[i];
        end
        // stride slot is addr_slot - 1, none for slot 0
        for (int i = 0; i < 3; i++)
        begin
            strs[i] = (as == 2'(i + 1)) ? stride_new_reg : str_rd_reg[i];
        end
    end

    // spatial and distinct-pc tests
    logic spatial, control;
    logic [2:0] npc;
    logic signed [64:0] dev [3];
    logic signed [64:0] tol_hi, tol_lo;
    assign tol_hi = $signed({53'd0, stride_tolerance});
    assign tol_lo = -tol_hi;
    always_comb
    begin
        spatial = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            dev[i] = $signed({strs[i][63], strs[i]}) - $signed({strs[0][63], strs[0]});
            if (dev[i] > tol_hi || dev[i] < tol_lo) spatial = 1'b0;
        end
        npc = 3'd1;
        if (pcs[1] != pcs[0]) npc = npc + 3'd1;
        if (pcs[2] != pcs[0] && pcs[2] != pcs[1]) npc = npc + 3'd1;
        if (pcs[3] != pcs[0] && pcs[3] != pcs[1] && pcs[3] != pcs[2]) npc = npc + 3'd1;
        control = (npc > 3'd2);
    end

    // next meta word
    logic [2:0]  wnext;
    logic [15:0] pnext;
    logic [1:0]  mnext;
    always_comb
    begin
        wnext = (wcnt < arl_pkg::WARMUP_DONE) ? wcnt + 3'd1 : wcnt;
        pnext = pcnt + 16'd1;
        mnext = md;
        if (pnext >= reeval_period)
        begin
            pnext = 16'd0;
            if (wnext >= arl_pkg::WARMUP_DONE && spatial)      mnext = arl_pkg::MODE_SPATIAL;
            else if (wnext >= arl_pkg::WARMUP_DONE && control) mnext = arl_pkg::MODE_LFU;
            else                                               mnext = arl_pkg::MODE_SRRIP;
        end
    end

    // line update values
    logic [1:0] rrv_wr;
    logic [7:0] freq_wr;
    always_comb
    begin
        if (hit_reg)
        begin
            rrv_wr  = 2'd0;
            freq_wr = (freq_rd_reg < arl_pkg::FREQ_MAX) ? freq_rd_reg + 8'd1 : freq_rd_reg;
        end
        else
        begin
            freq_wr = 8'd1;
            unique case (meta_new_reg[20:19])
                arl_pkg::MODE_SPATIAL: rrv_wr = 2'd0;
                arl_pkg::MODE_LFU:     rrv_wr = arl_pkg::RRV_MAX;
                default:               rrv_wr = arl_pkg::RRV_SRRIP_INSERT;
            endcase
        end
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step && !clr_cnt_reg[arl_pkg::LINE_W])
        begin
            rrv_mem[clr_cnt_reg[arl_pkg::LINE_W-1:0]]  <= arl_pkg::RRV_MAX;
            freq_mem[clr_cnt_reg[arl_pkg::LINE_W-1:0]] <= 8'd0;
            if (clr_cnt_reg[arl_pkg::LINE_W-1:arl_pkg::SET_W] == '0)
            begin
                pc_mem[clr_cnt_reg[arl_pkg::SET_W-1:0]]   <= '0;
                addr_mem[clr_cnt_reg[arl_pkg::SET_W-1:0]] <= '0;
                str_mem[clr_cnt_reg[arl_pkg::SET_W-1:0]]  <= '0;
                meta_mem[clr_cnt_reg[arl_pkg::SET_W-1:0]] <= 25'd0;
            end
        end
        else if (cmd.commit)
        begin
            meta_mem[set_reg]   <= meta_new_reg;
            pc_mem[set_reg]     <= pcs;
            addr_mem[set_reg]   <= addrs;
            str_mem[set_reg]    <= strs;
            rrv_mem[line_addr]  <= rrv_wr;
            freq_mem[line_addr] <= freq_wr;
        end
        rrv_rd_reg  <= rrv_mem[line_addr];
        freq_rd_reg <= freq_mem[line_addr];
        meta_rd_reg <= meta_mem[set_reg];
        pc_rd_reg   <= pc_mem[set_reg];
        addr_rd_reg <= addr_mem[set_reg];
        str_rd_reg  <= str_mem[set_reg];
    end

    // control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            scan_cnt_reg   <= '0;
            scan_rd_reg    <= 1'b0;
            done           <= 1'b0;
            set_ok_reg     <= 1'b0;
            act_reg        <= arl_pkg::ACT_QUERY;
            set_reg        <= '0;
            way_reg        <= '0;
            addr_reg       <= '0;
            pc_reg         <= '0;
            hit_reg        <= 1'b0;
            top_reg        <= 2'd0;
            least_reg      <= 9'd256;
            best_reg       <= '0;
            meta_new_reg   <= '0;
            stride_new_reg <= '0;
            victim_way     <= '0;
            set_mode       <= arl_pkg::MODE_SRRIP;
        end
        else
        begin
            done <= cmd.out;
            if (cmd.clr_step && !clr_cnt_reg[arl_pkg::LINE_W])
                clr_cnt_reg <= clr_cnt_reg + (arl_pkg::LINE_W + 1)'(1);
            if (cmd.load)
            begin
                act_reg    <= action;
                set_reg    <= set_index;
                way_reg    <= way_index;
                addr_reg   <= phys_addr;
                pc_reg     <= prog_counter;
                hit_reg    <= was_hit;
                set_ok_reg <= 1'b1;
            end
            if (cmd.read_set)
            begin
                scan_cnt_reg <= '0;
                scan_rd_reg  <= 1'b0;
                top_reg      <= 2'd0;
                least_reg    <= 9'd256;
                best_reg     <= '0;
            end
            // one way per cycle: read issued, then compared
            if (cmd.scan)
            begin
                if (!scan_cnt_reg[arl_pkg::WAY_W])
                    scan_cnt_reg <= scan_cnt_reg + (arl_pkg::WAY_W + 1)'(1);
                scan_rd_reg <= 1'b1;
            end
            if (cmd.scan && scan_rd_reg)
            begin
                if (rrv_rd_reg > top_reg)
                begin
                    top_reg   <= rrv_rd_reg;
                    least_reg <= {1'b0, freq_rd_reg};
                    best_reg  <= scan_cnt_reg[arl_pkg::WAY_W-1:0] - (arl_pkg::WAY_W)'(1);
                end
                else if (rrv_rd_reg == top_reg && {1'b0, freq_rd_reg} < least_reg)
                begin
                    least_reg <= {1'b0, freq_rd_reg};
                    best_reg  <= scan_cnt_reg[arl_pkg::WAY_W-1:0] - (arl_pkg::WAY_W)'(1);
                end
            end
            // new address minus the one in the slot about to be overwritten
            if (cmd.stride)
                stride_new_reg <= addr_reg - addr_rd_reg[as];
            if (cmd.eval)
                meta_new_reg <= {ps + 2'd1, as + 2'd1, mnext, pnext, wnext};
            if (cmd.out)
            begin
                victim_way <= stat.is_query ? best_reg : '0;
                set_mode   <= stat.is_query ? md
                                            : meta_new_reg[20:19];
            end
        end
    end

endmodule

>>> hdl/adaptive_rrip_lfu_replacement.sv
// channel | signals                                        | handshake
// input   | action set_index way_index phys_addr ...       | start & !busy
// result  | victim_way set_mode                            | done, one cycle
// config  | psel penable pwrite paddr pwdata prdata        | pready always high
// A query steps through read, a scan over all ways, and out before done strobes.
// An update steps through read, stride, evaluate, write back and out before done strobes.
// After reset a clearing pass over all lines holds busy high.
// Results cannot be stalled; the next word can be taken in the cycle done is high.
module adaptive_rrip_lfu_replacement
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [10:0] set_index,
    input  logic [3:0]  way_index,
    input  logic [63:0] phys_addr,
    input  logic [63:0] prog_counter,
    input  logic        was_hit,
    output logic        done,
    output logic [3:0]  victim_way,
    output logic [1:0]  set_mode,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:2]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    arl_pkg::arl_cmd_t  cmd;
    arl_pkg::arl_stat_t stat;
    logic [15:0] period_reg;
    logic [11:0] tol_reg;

    // register file
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= arl_pkg::PERIOD_RESET;
            tol_reg    <= arl_pkg::TOL_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == arl_pkg::ADDR_PERIOD) period_reg <= pwdata[15:0];
            else                               tol_reg    <= pwdata[11:0];
        end
    end
    assign prdata = (paddr == arl_pkg::ADDR_PERIOD) ? {16'd0, period_reg} : {20'd0, tol_reg};

    arl_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    arl_dp u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .reeval_period    (period_reg),
        .stride_tolerance (tol_reg),
        .action           (action),
        .set_index        (set_index),
        .way_index        (way_index),
        .phys_addr        (phys_addr),
        .prog_counter     (prog_counter),
        .was_hit          (was_hit),
        .done             (done),
        .victim_way       (victim_way),
        .set_mode         (set_mode)
    );

endmodule

>>> hdl/arl_checker.sv
`include "adaptive_rrip_lfu_replacement_assert.svh"
module arl_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] set_mode,
    input logic       pready
);
    `ARL_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ARL_ASSERT_IMPL(a_done_busy, clk, rst_n, done, busy == 1'b0)
    `ARL_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `ARL_ASSERT_IMPL(a_mode_code, clk, rst_n, done, set_mode != 2'd3)
    `ARL_ASSERT_IMPL(a_ready, clk, rst_n, 1'b1, pready)
endmodule

bind adaptive_rrip_lfu_replacement arl_checker u_arl_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .set_mode (set_mode),
    .pready   (pready)
);
